// ===== rtl/core/psalu_pkg.sv =====
// psalu_pkg: shared widths, operation codes and lane size codes of the packed alu
// no dependencies; compiled first

package psalu_pkg;

	localparam int WORD_BITS = 64;
	localparam int HALF_BITS = WORD_BITS / 2;
	localparam int BYTES     = WORD_BITS / 8;
	localparam int OP_BITS   = 4;
	localparam int LANE_BITS = 2;
	localparam int IMM_BITS  = 6;

	typedef enum logic [OP_BITS-1:0] {
		OP_ADD   = 4'd0,
		OP_SUB   = 4'd1,
		OP_MUL   = 4'd2,
		OP_SHL_V = 4'd3,
		OP_SRA_V = 4'd4,
		OP_SRL_V = 4'd5,
		OP_SHL_I = 4'd6,
		OP_SRA_I = 4'd7,
		OP_SRL_I = 4'd8,
		OP_AND   = 4'd9,
		OP_ANDN  = 4'd10,
		OP_OR    = 4'd11,
		OP_XOR   = 4'd12,
		OP_SEL   = 4'd13
	} op_t;

	typedef enum logic [LANE_BITS-1:0] {
		LANE_8  = 2'd0,
		LANE_16 = 2'd1,
		LANE_32 = 2'd2,
		LANE_64 = 2'd3
	} lane_t;

endpackage

// ===== rtl/core/psalu_if.sv =====
// psalu_cmd_if and psalu_rsp_if: valid/ready channels of the packed alu
// depends on psalu_pkg

interface psalu_cmd_if;
	import psalu_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [OP_BITS-1:0]   op;
	logic [LANE_BITS-1:0] lane_size;
	logic [WORD_BITS-1:0] operand_a;
	logic [WORD_BITS-1:0] operand_b;
	logic [WORD_BITS-1:0] operand_c;
	logic [IMM_BITS-1:0]  shift_imm;

	modport source (output valid, op, lane_size, operand_a, operand_b, operand_c, shift_imm,
		input ready);
	modport sink (input valid, op, lane_size, operand_a, operand_b, operand_c, shift_imm,
		output ready);
endinterface

interface psalu_rsp_if;
	import psalu_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [WORD_BITS-1:0] result;

	modport source (output valid, result, input ready);
	modport sink (input valid, result, output ready);
endinterface

// ===== rtl/core/packed_simd_integer_alu_core.sv =====
// packed_simd_integer_alu_core: three-stage packed integer alu over one 64-bit word
// depends on psalu_pkg and the channel interfaces in psalu_if.sv

// Takes one item per cycle while the output side is not stalled. Stage 1 registers
// the operands together with the segmented add/sub and the bitwise results; stage 2
// holds the lane products and the lane shifts; stage 3 merges the partial products of
// 64-bit lanes and picks the result. The multiplier is cut into 32x32 partial
// products in stage 2 and summed in stage 3. Each stage holds its item while the
// one after it is full and held itself, and an empty stage fills even while the
// result waits.
module packed_simd_integer_alu_core (
	input  logic               clk,
	input  logic               arst_n,
	psalu_cmd_if.sink          cmd,
	psalu_rsp_if.source        rsp
);
	import psalu_pkg::*;

	// stage enables
	logic en_s1, en_s2, en_s3;
	logic valid_s1, valid_s2, valid_s3;

	// stage 1 registers
	op_t                  op_s1;
	lane_t                lane_s1;
	logic [WORD_BITS-1:0] a_s1, b_s1, simple_s1;
	logic [IMM_BITS-1:0]  imm_s1;

	// stage 2 registers
	logic                 is_mul_s2;
	lane_t                lane_s2;
	logic [WORD_BITS-1:0] prod8_s2, prod16_s2, m0_s2, other_s2;
	logic [HALF_BITS-1:0] m1_s2, m2_s2;

	// stage 3 registers
	logic [WORD_BITS-1:0] result_s3;

	assign en_s3     = !valid_s3 || rsp.ready;
	assign en_s2     = !valid_s2 || en_s3;
	assign en_s1     = !valid_s1 || en_s2;
	assign cmd.ready = en_s1;
	assign rsp.valid = valid_s3;
	assign rsp.result = result_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en_s1) begin
				valid_s1 <= cmd.valid;
			end
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
			if (en_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	// ---------------- stage 1: add/sub and bitwise ops ----------------
	logic [WORD_BITS-1:0] simple_d;

	always_comb begin : p_simple
		logic [BYTES-1:0]     lane_start;
		logic [WORD_BITS-1:0] sum;
		logic [8:0]           bsum;
		logic                 carry;
		logic                 is_sub;
		lane_start = '0;
		sum        = '0;
		bsum       = '0;
		carry      = 1'b0;
		is_sub     = (op_t'(cmd.op) == OP_SUB);
		unique case (lane_t'(cmd.lane_size))
			LANE_8:  lane_start = 8'hFF;
			LANE_16: lane_start = 8'h55;
			LANE_32: lane_start = 8'h11;
			LANE_64: lane_start = 8'h01;
			default: lane_start = 8'h01;
		endcase
		// carry chain broken at every lane boundary
		for (int k = 0; k < BYTES; k++) begin
			if (lane_start[k]) begin
				carry = is_sub;
			end
			bsum = {1'b0, cmd.operand_a[k*8 +: 8]}
				+ {1'b0, cmd.operand_b[k*8 +: 8] ^ {8{is_sub}}}
				+ {8'd0, carry};
			sum[k*8 +: 8] = bsum[7:0];
			carry = bsum[8];
		end
		case (op_t'(cmd.op)) inside
			OP_ADD, OP_SUB: simple_d = sum;
			OP_AND:         simple_d = cmd.operand_a & cmd.operand_b;
			OP_ANDN:        simple_d = cmd.operand_a & ~cmd.operand_b;
			OP_OR:          simple_d = cmd.operand_a | cmd.operand_b;
			OP_XOR:         simple_d = cmd.operand_a ^ cmd.operand_b;
			OP_SEL:         simple_d = (cmd.operand_a & cmd.operand_b)
				| (~cmd.operand_a & cmd.operand_c);
			default:        simple_d = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en_s1 && cmd.valid) begin
			op_s1     <= op_t'(cmd.op);
			lane_s1   <= lane_t'(cmd.lane_size);
			a_s1      <= cmd.operand_a;
			b_s1      <= cmd.operand_b;
			imm_s1    <= cmd.shift_imm;
			simple_s1 <= simple_d;
		end
	end

	// ---------------- stage 2: lane products and shifts ----------------
	logic is_shift, sh_left, sh_arith, sh_var;

	always_comb begin
		is_shift = 1'b1;
		sh_left  = 1'b0;
		sh_arith = 1'b0;
		sh_var   = 1'b0;
		case (op_s1) inside
			OP_SHL_V:           begin sh_left = 1'b1; sh_var = 1'b1; end
			OP_SRA_V:           begin sh_arith = 1'b1; sh_var = 1'b1; end
			OP_SRL_V:           sh_var = 1'b1;
			OP_SHL_I:           sh_left = 1'b1;
			OP_SRA_I:           sh_arith = 1'b1;
			OP_SRL_I:           is_shift = 1'b1;
			default:            is_shift = 1'b0;
		endcase
	end

	logic [3:0][WORD_BITS-1:0] shift_w;
	logic [WORD_BITS-1:0]      prod8, prod16, m0;
	logic [HALF_BITS-1:0]      m1, m2, m1_a;

	for (genvar g = 0; g < 4; g++) begin : g_size
		localparam int W  = 8 << g;
		localparam int AW = 3 + g;
		localparam int L  = WORD_BITS / W;
		for (genvar l = 0; l < L; l++) begin : g_lane
			logic [W-1:0]  x, shl, srl, sra;
			logic [AW-1:0] sh, sra_amt;
			logic          big;
			assign x   = a_s1[l*W +: W];
			assign sh  = sh_var ? b_s1[l*W +: AW] : imm_s1[AW-1:0];
			// amount of at least the lane width
			assign big = sh_var ? (|b_s1[l*W+AW +: W-AW]) : ((imm_s1 >> AW) != '0);
			assign sra_amt = big ? AW'(W - 1) : sh;
			assign shl = big ? '0 : (x << sh);
			assign srl = big ? '0 : (x >> sh);
			assign sra = $unsigned($signed(x) >>> sra_amt);
			assign shift_w[g][l*W +: W] = sh_left ? shl : (sh_arith ? sra : srl);
		end
	end

	for (genvar i = 0; i < WORD_BITS / 8; i++) begin : g_mul8
		assign prod8[i*8 +: 8] = a_s1[i*8 +: 8] * b_s1[i*8 +: 8];
	end

	for (genvar i = 0; i < WORD_BITS / 16; i++) begin : g_mul16
		assign prod16[i*16 +: 16] = a_s1[i*16 +: 16] * b_s1[i*16 +: 16];
	end

	// 32x32 partials: low*low full, then two cross terms (or high*high for 32-bit lanes)
	assign m1_a = (lane_s1 == LANE_64) ? a_s1[HALF_BITS-1:0] : a_s1[WORD_BITS-1:HALF_BITS];
	assign m0   = WORD_BITS'(a_s1[HALF_BITS-1:0]) * WORD_BITS'(b_s1[HALF_BITS-1:0]);
	assign m1   = m1_a * b_s1[WORD_BITS-1:HALF_BITS];
	assign m2   = a_s1[WORD_BITS-1:HALF_BITS] * b_s1[HALF_BITS-1:0];

	always_ff @(posedge clk) begin
		if (en_s2 && valid_s1) begin
			is_mul_s2 <= (op_s1 == OP_MUL);
			lane_s2   <= lane_s1;
			prod8_s2  <= prod8;
			prod16_s2 <= prod16;
			m0_s2     <= m0;
			m1_s2     <= m1;
			m2_s2     <= m2;
			other_s2  <= is_shift ? shift_w[lane_s1] : simple_s1;
		end
	end

	// ---------------- stage 3: product merge and result select ----------------
	logic [WORD_BITS-1:0] mul_res;

	always_comb begin
		unique case (lane_s2)
			LANE_8:  mul_res = prod8_s2;
			LANE_16: mul_res = prod16_s2;
			LANE_32: mul_res = {m1_s2, m0_s2[HALF_BITS-1:0]};
			LANE_64: mul_res = m0_s2 + {(m1_s2 + m2_s2), {HALF_BITS{1'b0}}};
			default: mul_res = m0_s2;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en_s3 && valid_s2) begin
			result_s3 <= is_mul_s2 ? mul_res : other_s2;
		end
	end

	// ---------------- assertions ----------------
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && valid_s3 && !rsp.ready |-> !cmd.ready)
		else $error("input taken while every stage is full and the output stalls");

	a_s2_advance: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !valid_s3 |=> valid_s3)
		else $error("item in stage 2 did not move into an empty stage 3");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !en_s1 |=> valid_s1 && $stable(op_s1) && $stable(a_s1))
		else $error("stalled stage 1 item was lost or changed");

endmodule
